// ===== rtl/core/brf_pkg.sv =====
`default_nettype none

package brf_pkg;

  localparam int unsigned DEPTH_DEFAULT = 256;
  localparam int unsigned CMD_W         = 3;
  localparam int unsigned DATA_W        = 8;
  localparam int unsigned OFF_W         = 8;
  localparam int unsigned CNT_W         = 8;
  localparam int unsigned OVF_W         = 32;
  localparam int unsigned SIZE_W        = 9;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 3'd0,
    CMD_READ    = 3'd1,
    CMD_DISCARD = 3'd2,
    CMD_PEEK    = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_STATUS  = 3'd5
  } cmd_e;

  typedef struct packed {
    logic exec;
    logic fetch;
  } brf_ctrl_t;

  typedef struct packed {
    logic needs_mem;
  } brf_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/brf_if.sv =====
`default_nettype none

interface brf_in_if;
  import brf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [DATA_W-1:0] data_in;
  logic [OFF_W-1:0]  peek_offset;

  modport source (output valid, command, data_in, peek_offset, input ready);
  modport sink   (input valid, command, data_in, peek_offset, output ready);
endinterface

interface brf_out_if;
  import brf_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;
  logic              ok;
  logic [CNT_W-1:0]  data_count;
  logic [CNT_W-1:0]  space_count;
  logic [OVF_W-1:0]  overflow_count;

  modport source (output valid, data_out, ok, data_count, space_count, overflow_count,
                  input ready);
  modport sink   (input valid, data_out, ok, data_count, space_count, overflow_count,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/byte_ring_fifo_with_peek.sv =====
// Byte ring FIFO with peek.
// in_i carries one command word (write, read, discard, peek, clear, status)
// with its data byte and peek offset; out_o returns exactly one result word
// per command: data byte, ok flag, data count, space count, overflow count.
// cfg_we_i/cfg_wdata_i set the ring length (capacity is one less) and empty
// the ring; write it only while no command is in flight.
// A read or a successful peek shows its result after the registered RAM read
// and the ST_FETCH state; every other command shows it in the cycle after
// the accept edge. One command is in flight at a time: a new command is
// not accepted until out_o has taken the result of the last one.
// While the result word waits for out_o.ready, in_i.ready stays low and the
// result is held stable.
// Reset: empty ring, overflow count zero, ring length 256, clamped to DEPTH.
// Storage has no reset and no clearing pass; only written slots are read.
`default_nettype none

module byte_ring_fifo_with_peek #(
  parameter int unsigned DEPTH = brf_pkg::DEPTH_DEFAULT
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [brf_pkg::SIZE_W-1:0] cfg_wdata_i,
  brf_in_if.sink                          in_i,
  brf_out_if.source                       out_o
);
  import brf_pkg::*;

  brf_ctrl_t ctrl;
  brf_stat_t stat;

  brf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  brf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .command_i        (in_i.command),
    .data_in_i        (in_i.data_in),
    .peek_offset_i    (in_i.peek_offset),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .data_out_o       (out_o.data_out),
    .ok_o             (out_o.ok),
    .data_count_o     (out_o.data_count),
    .space_count_o    (out_o.space_count),
    .overflow_count_o (out_o.overflow_count)
  );

endmodule

`default_nettype wire

// ===== rtl/core/brf_ram.sv =====
`default_nettype none

module brf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/brf_datapath.sv =====
`default_nettype none

module brf_datapath #(
  parameter int unsigned DEPTH = brf_pkg::DEPTH_DEFAULT
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [brf_pkg::SIZE_W-1:0]  cfg_wdata_i,
  input  wire logic [brf_pkg::CMD_W-1:0]   command_i,
  input  wire logic [brf_pkg::DATA_W-1:0]  data_in_i,
  input  wire logic [brf_pkg::OFF_W-1:0]   peek_offset_i,
  input  wire brf_pkg::brf_ctrl_t          ctrl_i,
  output      brf_pkg::brf_stat_t          stat_o,
  output      logic [brf_pkg::DATA_W-1:0]  data_out_o,
  output      logic                        ok_o,
  output      logic [brf_pkg::CNT_W-1:0]   data_count_o,
  output      logic [brf_pkg::CNT_W-1:0]   space_count_o,
  output      logic [brf_pkg::OVF_W-1:0]   overflow_count_o
);
  import brf_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned LEN_W = $clog2(DEPTH + 1);
  localparam int unsigned AW    = ((LEN_W > SIZE_W) ? LEN_W : SIZE_W) + 1;

  logic [SIZE_W-1:0] size_q;
  logic [PTR_W-1:0]  rd_q, rd_d;
  logic [PTR_W-1:0]  wr_q, wr_d;
  logic [OVF_W-1:0]  drop_q, drop_d;

  logic [AW-1:0]     size_a, len, rd_a, wr_a, rd_n, wr_n;
  logic [AW-1:0]     count, count_after, space_after;
  logic [AW-1:0]     wr_inc, rd_inc, peek_p;
  logic              full;
  logic              ok_n;
  logic              ram_we;
  logic [PTR_W-1:0]  raddr;
  logic [DATA_W-1:0] ram_rdata;

  always_comb begin
    size_a = AW'(size_q);
    priority if (size_a < AW'(SIZE_MIN)) begin
      len = AW'(SIZE_MIN);
    end else if (size_a > AW'(DEPTH)) begin
      len = AW'(DEPTH);
    end else begin
      len = size_a;
    end
  end

  always_comb begin
    rd_a   = AW'(rd_q);
    wr_a   = AW'(wr_q);
    count  = (rd_a <= wr_a) ? (wr_a - rd_a) : (wr_a + len - rd_a);
    full   = (count + AW'(1)) >= len;
    wr_inc = wr_a + AW'(1);
    rd_inc = rd_a + AW'(1);
    peek_p = rd_a + AW'(peek_offset_i);
    if (peek_p >= len) begin
      peek_p = peek_p - len;
    end
  end

  always_comb begin
    rd_d             = rd_q;
    wr_d             = wr_q;
    drop_d           = drop_q;
    ram_we           = 1'b0;
    raddr            = rd_q;
    ok_n             = 1'b0;
    stat_o.needs_mem = 1'b0;
    if (cfg_we_i) begin
      rd_d = '0;
      wr_d = '0;
    end else if (ctrl_i.exec) begin
      unique case (cmd_e'(command_i))
        CMD_WRITE: begin
          if (full) begin
            drop_d = drop_q + OVF_W'(1);
          end else begin
            ram_we = 1'b1;
            wr_d   = (wr_inc >= len) ? '0 : PTR_W'(wr_inc);
            ok_n   = 1'b1;
          end
        end
        CMD_READ, CMD_DISCARD: begin
          if (count != '0) begin
            rd_d             = (rd_inc >= len) ? '0 : PTR_W'(rd_inc);
            ok_n             = 1'b1;
            stat_o.needs_mem = (cmd_e'(command_i) == CMD_READ);
          end
        end
        CMD_PEEK: begin
          if (AW'(peek_offset_i) < count) begin
            raddr            = PTR_W'(peek_p);
            ok_n             = 1'b1;
            stat_o.needs_mem = 1'b1;
          end
        end
        CMD_CLEAR: begin
          rd_d   = '0;
          wr_d   = '0;
          drop_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rd_n        = AW'(rd_d);
    wr_n        = AW'(wr_d);
    count_after = (rd_n <= wr_n) ? (wr_n - rd_n) : (wr_n + len - rd_n);
    space_after = len - count_after - AW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
      rd_q   <= '0;
      wr_q   <= '0;
      drop_q <= '0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      rd_q   <= rd_d;
      wr_q   <= wr_d;
      drop_q <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      data_out_o       <= '0;
      ok_o             <= ok_n;
      data_count_o     <= count_after[CNT_W-1:0];
      space_count_o    <= space_after[CNT_W-1:0];
      overflow_count_o <= drop_d;
    end else if (ctrl_i.fetch) begin
      data_out_o <= ram_rdata;
    end
  end

  brf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_q),
    .wdata_i (data_in_i),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/brf_ctrl.sv =====
`default_nettype none

module brf_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  input  wire brf_pkg::brf_stat_t stat_i,
  output      brf_pkg::brf_ctrl_t ctrl_o
);
  import brf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SEND
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  assign in_ready_o   = in_ready_q;
  assign out_valid_o  = out_valid_q;
  assign ctrl_o.exec  = in_valid_i && in_ready_q;
  assign ctrl_o.fetch = (state_q == ST_FETCH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            in_ready_q <= 1'b0;
            if (stat_i.needs_mem) begin
              state_q <= ST_FETCH;
            end else begin
              state_q     <= ST_SEND;
              out_valid_q <= 1'b1;
            end
          end
        end
        ST_FETCH: begin
          state_q     <= ST_SEND;
          out_valid_q <= 1'b1;
        end
        ST_SEND: begin
          if (out_ready_i) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b0;
          in_ready_q  <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== bench/brf_checker.sv =====
module brf_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [brf_pkg::SIZE_W-1:0] cfg_wdata_i,
  brf_in_if                          in_ch,
  brf_out_if                         out_ch,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o,
  output int unsigned                results_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import brf_pkg::*;

  localparam int unsigned PRINT_LIMIT = 40;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              ok;
    logic [CNT_W-1:0]  data_count;
    logic [CNT_W-1:0]  space_count;
    logic [OVF_W-1:0]  overflow_count;
  } brf_result_t;

  logic [DATA_W-1:0] ring_mem [DEPTH_DEFAULT];
  logic [7:0]        head_q;
  logic [7:0]        tail_q;
  logic [OVF_W-1:0]  dropped_q;
  logic [SIZE_W-1:0] size_q;
  brf_result_t       expected_q [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    results_o    = 0;
  end

  function automatic logic [SIZE_W-1:0] ring_len();
    if (size_q < SIZE_MIN) begin
      return SIZE_MIN;
    end
    if (size_q > DEPTH_DEFAULT) begin
      return SIZE_W'(DEPTH_DEFAULT);
    end
    return size_q;
  endfunction

  function automatic logic [SIZE_W-1:0] fill_level(input logic [SIZE_W-1:0] len);
    if (tail_q >= head_q) begin
      return SIZE_W'(tail_q) - SIZE_W'(head_q);
    end
    return SIZE_W'(tail_q) + len - SIZE_W'(head_q);
  endfunction

  function automatic logic [7:0] next_slot(input logic [7:0] p, input logic [SIZE_W-1:0] len);
    return (SIZE_W'(p) + SIZE_W'(1) >= len) ? 8'd0 : p + 8'd1;
  endfunction

  function automatic brf_result_t apply_command(input logic [CMD_W-1:0]  cmd,
                                                input logic [DATA_W-1:0] din,
                                                input logic [OFF_W-1:0]  off);
    logic [SIZE_W-1:0] len;
    logic [SIZE_W-1:0] held;
    logic [SIZE_W-1:0] pos;
    brf_result_t       res;
    len  = ring_len();
    held = fill_level(len);
    res  = '0;
    case (cmd)
      CMD_WRITE: begin
        if (held + SIZE_W'(1) >= len) begin
          dropped_q = dropped_q + 1'b1;
        end else begin
          ring_mem[tail_q] = din;
          tail_q = next_slot(tail_q, len);
          res.ok = 1'b1;
        end
      end
      CMD_READ, CMD_DISCARD: begin
        if (held != 0) begin
          if (cmd == CMD_READ) begin
            res.data_out = ring_mem[head_q];
          end
          head_q = next_slot(head_q, len);
          res.ok = 1'b1;
        end
      end
      CMD_PEEK: begin
        if (SIZE_W'(off) < held) begin
          pos = SIZE_W'(head_q) + SIZE_W'(off);
          if (pos >= len) begin
            pos = pos - len;
          end
          res.data_out = ring_mem[pos[7:0]];
          res.ok = 1'b1;
        end
      end
      CMD_CLEAR: begin
        head_q    = '0;
        tail_q    = '0;
        dropped_q = '0;
      end
      default: ;
    endcase
    held = fill_level(len);
    res.data_count     = held[CNT_W-1:0];
    res.space_count    = CNT_W'(len - held - SIZE_W'(1));
    res.overflow_count = dropped_q;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count_o < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fail_count_o++;
  endtask

  task automatic check_result();
    brf_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result word with nothing pending");
      return;
    end
    want = expected_q.pop_front();
    results_o++;
    if (out_ch.data_out !== want.data_out) begin
      report_mismatch($sformatf("data_out got %0h, expected %0h", out_ch.data_out,
                                want.data_out));
    end
    if (out_ch.ok !== want.ok) begin
      report_mismatch($sformatf("ok got %0b, expected %0b", out_ch.ok, want.ok));
    end
    if (out_ch.data_count !== want.data_count) begin
      report_mismatch($sformatf("data_count got %0d, expected %0d", out_ch.data_count,
                                want.data_count));
    end
    if (out_ch.space_count !== want.space_count) begin
      report_mismatch($sformatf("space_count got %0d, expected %0d", out_ch.space_count,
                                want.space_count));
    end
    if (out_ch.overflow_count !== want.overflow_count) begin
      report_mismatch($sformatf("overflow_count got %0d, expected %0d",
                                out_ch.overflow_count, want.overflow_count));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    = '0;
      tail_q    = '0;
      dropped_q = '0;
      size_q    = SIZE_RESET;
      expected_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_result();
      end
      if (cfg_we_i) begin
        size_q = cfg_wdata_i;
        head_q = '0;
        tail_q = '0;
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(apply_command(in_ch.command, in_ch.data_in, in_ch.peek_offset));
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brf_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  typedef enum int unsigned {SEG_FILL, SEG_DRAIN, SEG_MIXED, SEG_PEEK} seg_e;
  typedef enum int unsigned {RX_FREE, RX_MOSTLY_READY, RX_MOSTLY_STALLED, RX_PERIODIC} rx_mode_e;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       results;
  int unsigned       words_sent;
  int unsigned       sizes_used;
  int unsigned       burst_left;
  int unsigned       stall_left;
  rx_mode_e          rx_mode;

  brf_in_if  in_ch();
  brf_out_if out_ch();

  byte_ring_fifo_with_peek DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  brf_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("byte_ring_fifo_with_peek test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      rx_mode    = rx_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    case (rx_mode)
      RX_FREE:           out_ch.ready <= 1'b1;
      RX_MOSTLY_READY:   out_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_MOSTLY_STALLED: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default:           out_ch.ready <= stall_left[2];
    endcase
  end

  function automatic int unsigned ring_capacity(input logic [SIZE_W-1:0] sz);
    if (sz < SIZE_MIN) begin
      return SIZE_MIN - 1;
    end
    if (sz > DEPTH_DEFAULT) begin
      return DEPTH_DEFAULT - 1;
    end
    return sz - 1;
  endfunction

  task automatic send_word(input logic [CMD_W-1:0]  cmd,
                           input logic [DATA_W-1:0] din,
                           input logic [OFF_W-1:0]  off);
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.data_in     <= din;
    in_ch.peek_offset <= off;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  task automatic set_ring_size(input logic [SIZE_W-1:0] sz);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= sz;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sizes_used++;
  endtask

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  function automatic logic [CMD_W-1:0] next_command(input seg_e seg);
    case (seg)
      SEG_FILL: begin
        if ($urandom_range(0, 15) != 0) return CMD_WRITE;
        return ($urandom_range(0, 1) != 0) ? CMD_PEEK : CMD_STATUS;
      end
      SEG_DRAIN: begin
        if ($urandom_range(0, 15) == 0) return CMD_PEEK;
        return ($urandom_range(0, 3) != 0) ? CMD_READ : CMD_DISCARD;
      end
      SEG_PEEK: begin
        case ($urandom_range(0, 3))
          0:       return CMD_WRITE;
          1:       return CMD_READ;
          default: return CMD_PEEK;
        endcase
      end
      default: return CMD_W'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic run_phase(input int unsigned n_items, input int unsigned cap);
    seg_e              seg;
    int unsigned       seg_left;
    int unsigned       i;
    logic [CMD_W-1:0]  cmd;
    logic [OFF_W-1:0]  off;
    seg_left = 0;
    seg      = SEG_MIXED;
    for (i = 0; i < n_items; i++) begin
      if (seg_left == 0) begin
        seg      = seg_e'($urandom_range(0, 3));
        seg_left = (seg == SEG_FILL || seg == SEG_DRAIN) ? cap + $urandom_range(1, 4)
                                                         : $urandom_range(4, 32);
      end
      seg_left--;
      cmd = next_command(seg);
      off = ($urandom_range(0, 3) == 0) ? OFF_W'($urandom_range(0, 255))
                                        : OFF_W'($urandom_range(0, cap));
      pace_sender();
      send_word(cmd, DATA_W'($urandom_range(0, 255)), off);
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] ring_sizes [11];
    int unsigned       k;
    ring_sizes = '{9'd3, 9'd0, 9'd1, 9'd511, 9'd17, 9'd255, 9'd300, 9'd64, 9'd0, 9'd256,
                   9'd2};
    ring_sizes[8] = SIZE_W'($urandom_range(0, 511));
    words_sent  = 0;
    sizes_used  = 1;
    burst_left  = 0;
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CMD_STATUS;
    in_ch.data_in     <= '0;
    in_ch.peek_offset <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty ring, writes, peeks in and out of range, reads, spare codes
    send_word(CMD_STATUS,  8'h00, 8'h00);
    send_word(CMD_READ,    8'h00, 8'h00);
    send_word(CMD_DISCARD, 8'h00, 8'h00);
    send_word(CMD_PEEK,    8'h00, 8'h00);
    send_word(CMD_WRITE,   8'h00, 8'h00);
    send_word(CMD_WRITE,   8'hFF, 8'hFF);
    send_word(CMD_WRITE,   8'hA5, 8'h00);
    send_word(CMD_WRITE,   8'h5A, 8'h00);
    send_word(CMD_PEEK,    8'h00, 8'd0);
    send_word(CMD_PEEK,    8'h00, 8'd3);
    send_word(CMD_PEEK,    8'h00, 8'd4);
    send_word(CMD_PEEK,    8'h00, 8'hFF);
    send_word(CMD_READ,    8'h00, 8'h00);
    send_word(CMD_DISCARD, 8'h00, 8'h00);
    send_word(CMD_READ,    8'h00, 8'h00);
    send_word(CMD_RSVD6,   8'hFF, 8'hFF);
    send_word(CMD_RSVD7,   8'h3C, 8'hC3);
    send_word(CMD_CLEAR,   8'h00, 8'h00);

    // one-byte ring: drop on full, then clear the drop count
    set_ring_size(SIZE_MIN);
    send_word(CMD_WRITE, 8'h11, 8'h00);
    send_word(CMD_WRITE, 8'h22, 8'h00);
    send_word(CMD_PEEK,  8'h00, 8'h00);
    send_word(CMD_READ,  8'h00, 8'h00);
    send_word(CMD_READ,  8'h00, 8'h00);
    send_word(CMD_CLEAR, 8'h00, 8'h00);

    for (k = 0; k < 11; k++) begin
      set_ring_size(ring_sizes[k]);
      run_phase(ring_capacity(ring_sizes[k]) + 80, ring_capacity(ring_sizes[k]));
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d command words across %0d ring length settings", words_sent,
             sizes_used);
    $display("%0d result words compared, %0d mismatches", results, fail_count);
    if (fail_count == 0) begin
      $display("byte_ring_fifo_with_peek test passed");
    end else begin
      $display("byte_ring_fifo_with_peek test failed");
    end
    $finish;
  end

endmodule
